>>> hdl/plr_pkg.sv
package plr_pkg;

    // Default width of the internal screen coordinates.
    localparam int COORD_WIDTH_DEF = 12;

    // Fixed field widths of the channels and registers.
    localparam int IN_W    = 11;
    localparam int PIX_W   = 12;
    localparam int ORG_W   = 10;
    localparam int CFG_IDX_W = 1;
    localparam int PHASE_W = 4;

    localparam logic [ORG_W-1:0] ORIGIN_X_RST = ORG_W'(320);
    localparam logic [ORG_W-1:0] ORIGIN_Y_RST = ORG_W'(240);

    // The dash pattern repeats every PATTERN_LEN pixels.
    localparam logic [PHASE_W-1:0] PATTERN_LEN  = PHASE_W'(15);
    localparam logic [PHASE_W-1:0] PATTERN_LAST = PHASE_W'(14);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef struct packed {
        logic signed [PIX_W-1:0] pixel_x;
        logic signed [PIX_W-1:0] pixel_y;
        logic                    plot;
        logic                    last;
    } t_result;

    // Plot decision for a pixel whose number modulo the pattern length is phase.
    // X-major lines draw every third pixel; other lines skip one pixel in fifteen.
    function automatic logic dash_plot(input logic [PHASE_W-1:0] phase,
                                       input logic x_major);
        logic third;
        third = (phase == PHASE_W'(0)) || (phase == PHASE_W'(3)) ||
                (phase == PHASE_W'(6)) || (phase == PHASE_W'(9)) ||
                (phase == PHASE_W'(12));
        return x_major ? third : (phase != PHASE_W'(0));
    endfunction

endpackage

>>> hdl/plr_in_stage.sv
module plr_in_stage #(
    parameter int COORD_WIDTH = plr_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_take,
    input  plr_pkg::t_op                      i_op,
    input  logic signed [plr_pkg::IN_W-1:0]   i_start_x,
    input  logic signed [plr_pkg::IN_W-1:0]   i_start_y,
    input  logic signed [plr_pkg::IN_W-1:0]   i_end_x,
    input  logic signed [plr_pkg::IN_W-1:0]   i_end_y,
    input  logic [plr_pkg::ORG_W-1:0]         i_origin_x,
    input  logic [plr_pkg::ORG_W-1:0]         i_origin_y,
    output logic                              o_valid,
    output plr_pkg::t_op                      o_op,
    output logic signed [COORD_WIDTH-1:0]     o_x1,
    output logic signed [COORD_WIDTH-1:0]     o_y1,
    output logic signed [COORD_WIDTH-1:0]     o_x2,
    output logic signed [COORD_WIDTH-1:0]     o_y2
);

    logic                          r_valid;
    plr_pkg::t_op                  r_op;
    logic signed [COORD_WIDTH-1:0] r_x1, r_y1, r_x2, r_y2;
    logic signed [COORD_WIDTH-1:0] n_x1, n_y1, n_x2, n_y2;
    logic                          accept;

    // Map centred coordinates to screen coordinates, wrapping to the coordinate width.
    assign n_x1 = COORD_WIDTH'(i_start_x) + COORD_WIDTH'(i_origin_x);
    assign n_y1 = COORD_WIDTH'(i_origin_y) - COORD_WIDTH'(i_start_y);
    assign n_x2 = COORD_WIDTH'(i_end_x) + COORD_WIDTH'(i_origin_x);
    assign n_y2 = COORD_WIDTH'(i_origin_y) - COORD_WIDTH'(i_end_y);

    assign o_ready = !r_valid || i_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
            r_x1 <= n_x1;
            r_y1 <= n_y1;
            r_x2 <= n_x2;
            r_y2 <= n_y2;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_x1    = r_x1;
    assign o_y1    = r_y1;
    assign o_x2    = r_x2;
    assign o_y2    = r_y2;

endmodule

>>> hdl/plr_stepper.sv
module plr_stepper #(
    parameter int COORD_WIDTH = plr_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  plr_pkg::t_op                  i_op,
    input  logic signed [COORD_WIDTH-1:0] i_x1,
    input  logic signed [COORD_WIDTH-1:0] i_y1,
    input  logic signed [COORD_WIDTH-1:0] i_x2,
    input  logic signed [COORD_WIDTH-1:0] i_y2,
    output plr_pkg::t_result              o_result
);

    localparam int EW = COORD_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0]   r_pos_x, r_pos_y;
    logic signed [EW-1:0]            r_err;
    logic [COORD_WIDTH-1:0]          r_cnt, r_major, r_minor;
    logic                            r_dir_xn, r_dir_yn, r_xmaj, r_active;
    logic [plr_pkg::PHASE_W-1:0]     r_phase;

    logic signed [COORD_WIDTH-1:0]   n_pos_x, n_pos_y;
    logic signed [EW-1:0]            n_err;
    logic [COORD_WIDTH-1:0]          n_cnt, n_major, n_minor;
    logic                            n_dir_xn, n_dir_yn, n_xmaj, n_active;
    logic [plr_pkg::PHASE_W-1:0]     n_phase;

    // Load path.
    logic signed [COORD_WIDTH:0]     dx, dy;
    logic [COORD_WIDTH-1:0]          adx, ady, ld_major, ld_minor;
    logic                            ld_xmaj;
    logic signed [EW-1:0]            ld_err;

    // Step path.
    logic                            minor_move;
    logic signed [EW:0]              err_ext, two_minor, two_major, err_sum;
    logic signed [COORD_WIDTH-1:0]   step_x, step_y, adv_x, adv_y;
    logic [COORD_WIDTH-1:0]          cnt_inc;
    logic [plr_pkg::PHASE_W-1:0]     phase_inc;
    logic                            step_last;

    assign dx  = (COORD_WIDTH+1)'(i_x2) - (COORD_WIDTH+1)'(i_x1);
    assign dy  = (COORD_WIDTH+1)'(i_y2) - (COORD_WIDTH+1)'(i_y1);
    assign adx = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
    assign ady = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
    assign ld_xmaj  = adx > ady;
    assign ld_major = ld_xmaj ? adx : ady;
    assign ld_minor = ld_xmaj ? ady : adx;
    assign ld_err   = signed'({1'b0, ld_minor, 1'b0}) - signed'({2'b00, ld_major});

    // Bresenham error update: add twice the minor delta, and take twice the
    // major delta off whenever the minor axis moves too.
    assign minor_move = !r_err[EW-1];
    assign err_ext    = (EW+1)'(r_err);
    assign two_minor  = signed'({2'b00, r_minor, 1'b0});
    assign two_major  = signed'({2'b00, r_major, 1'b0});
    assign err_sum    = err_ext + two_minor - (minor_move ? two_major : '0);

    assign step_x = r_dir_xn ? {COORD_WIDTH{1'b1}} : COORD_WIDTH'(1);
    assign step_y = r_dir_yn ? {COORD_WIDTH{1'b1}} : COORD_WIDTH'(1);
    assign adv_x  = (r_xmaj || minor_move) ? r_pos_x + step_x : r_pos_x;
    assign adv_y  = (!r_xmaj || minor_move) ? r_pos_y + step_y : r_pos_y;

    assign cnt_inc   = r_cnt + COORD_WIDTH'(1);
    assign step_last = cnt_inc >= r_major;
    assign phase_inc = (r_phase == plr_pkg::PATTERN_LAST) ?
                       '0 : r_phase + plr_pkg::PHASE_W'(1);

    always_comb begin
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        n_err    = r_err;
        n_cnt    = r_cnt;
        n_major  = r_major;
        n_minor  = r_minor;
        n_dir_xn = r_dir_xn;
        n_dir_yn = r_dir_yn;
        n_xmaj   = r_xmaj;
        n_active = r_active;
        n_phase  = r_phase;
        o_result = '0;
        case (i_op)
            plr_pkg::OP_LOAD: begin
                n_pos_x  = i_x1;
                n_pos_y  = i_y1;
                n_err    = ld_err;
                n_cnt    = '0;
                n_major  = ld_major;
                n_minor  = ld_minor;
                n_dir_xn = i_x1 > i_x2;
                n_dir_yn = i_y1 > i_y2;
                n_xmaj   = ld_xmaj;
                n_active = ld_major != '0;
                n_phase  = plr_pkg::PHASE_W'(1);
                o_result.pixel_x = plr_pkg::PIX_W'(i_x1);
                o_result.pixel_y = plr_pkg::PIX_W'(i_y1);
                o_result.plot    = 1'b1;
                o_result.last    = ld_major == '0;
            end
            plr_pkg::OP_STEP: begin
                if (r_active) begin
                    n_pos_x  = adv_x;
                    n_pos_y  = adv_y;
                    n_err    = err_sum[EW-1:0];
                    n_cnt    = cnt_inc;
                    n_phase  = phase_inc;
                    n_active = !step_last;
                    o_result.pixel_x = plr_pkg::PIX_W'(adv_x);
                    o_result.pixel_y = plr_pkg::PIX_W'(adv_y);
                    o_result.plot    = plr_pkg::dash_plot(phase_inc, r_xmaj);
                    o_result.last    = step_last;
                end else begin
                    o_result.last = 1'b1;
                end
            end
            default: begin
                o_result.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_err    <= '0;
            r_cnt    <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_dir_xn <= 1'b0;
            r_dir_yn <= 1'b0;
            r_xmaj   <= 1'b0;
            r_active <= 1'b0;
            r_phase  <= '0;
        end else if (i_take) begin
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
            r_err    <= n_err;
            r_cnt    <= n_cnt;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_dir_xn <= n_dir_xn;
            r_dir_yn <= n_dir_yn;
            r_xmaj   <= n_xmaj;
            r_active <= n_active;
            r_phase  <= n_phase;
        end
    end

endmodule

>>> hdl/plr_out_reg.sv
module plr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  plr_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_can_take,
    output plr_pkg::t_result o_result
);

    logic             r_valid;
    plr_pkg::t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hdl/patterned_line_rasterizer_top.sv
// Patterned line rasterizer: a Bresenham line stepper with a fixed dash pattern.
// Input channel (i_in_valid / o_in_ready): each transaction carries an operation.
// A load transaction maps its two centred endpoints to screen coordinates using
// the origin registers and returns the first pixel, always plotted. A step
// transaction advances one pixel along the major axis and returns its position,
// the dash plot flag and a last flag; a step with no active line returns 0, 0,
// plot 0 and last 1. Output channel (o_out_valid / i_out_ready): one result
// transaction per input transaction, in order.
// A transaction passes through the input register (where the coordinate mapping is
// captured), then through the step logic into the result register, which drives
// o_out_valid. Throughput is one transaction per cycle while the receiver keeps
// taking results, as the stepper updates its state each time a transaction moves
// on into the result register.
// When the receiver stalls, the result register holds its transaction and the
// input register fills; o_in_ready drops only once both are occupied.
// Reset (i_rst_n low, synchronous) empties both registers, clears the line
// state so no line is active, and sets origin_x to 320 and origin_y to 240.
// The origin registers are written through i_cfg_we / i_cfg_index / i_cfg_data
// and must only change while the block is idle.
module patterned_line_rasterizer_top #(
    parameter int COORD_WIDTH = plr_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [plr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [plr_pkg::ORG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic signed [plr_pkg::IN_W-1:0]      i_start_x,
    input  logic signed [plr_pkg::IN_W-1:0]      i_start_y,
    input  logic signed [plr_pkg::IN_W-1:0]      i_end_x,
    input  logic signed [plr_pkg::IN_W-1:0]      i_end_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [plr_pkg::PIX_W-1:0]     o_pixel_x,
    output logic signed [plr_pkg::PIX_W-1:0]     o_pixel_y,
    output logic                                 o_plot,
    output logic                                 o_last
);

    // Origin configuration registers.
    logic [plr_pkg::ORG_W-1:0] r_origin_x, r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= plr_pkg::ORIGIN_X_RST;
            r_origin_y <= plr_pkg::ORIGIN_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plr_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                plr_pkg::REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic                          s1_valid;
    plr_pkg::t_op                  s1_op;
    logic signed [COORD_WIDTH-1:0] s1_x1, s1_y1, s1_x2, s1_y2;
    logic                          out_can_take;
    logic                          advance;
    plr_pkg::t_result              step_result;
    plr_pkg::t_result              out_result;

    // An item leaves the input register whenever the result register is empty
    // or is handing its transaction over in the same cycle.
    assign advance = s1_valid && out_can_take;

    plr_in_stage #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_take     (advance),
        .i_op       (plr_pkg::t_op'(i_operation)),
        .i_start_x  (i_start_x),
        .i_start_y  (i_start_y),
        .i_end_x    (i_end_x),
        .i_end_y    (i_end_y),
        .i_origin_x (r_origin_x),
        .i_origin_y (r_origin_y),
        .o_valid    (s1_valid),
        .o_op       (s1_op),
        .o_x1       (s1_x1),
        .o_y1       (s1_y1),
        .o_x2       (s1_x2),
        .o_y2       (s1_y2)
    );

    plr_stepper #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_stepper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (advance),
        .i_op     (s1_op),
        .i_x1     (s1_x1),
        .i_y1     (s1_y1),
        .i_x2     (s1_x2),
        .i_y2     (s1_y2),
        .o_result (step_result)
    );

    plr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (step_result),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_can_take (out_can_take),
        .o_result   (out_result)
    );

    assign o_pixel_x = out_result.pixel_x;
    assign o_pixel_y = out_result.pixel_y;
    assign o_plot    = out_result.plot;
    assign o_last    = out_result.last;

endmodule

>>> tb/sv/tb_patterned_line_rasterizer_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the patterned line rasterizer. Line commands are queued by
// the stimulus process. A clocked driver presents them on the input channel, and a
// clocked monitor predicts every accepted transaction and checks every result in order.
module tb_patterned_line_rasterizer_top;

    // The run is stopped as failed if it is still going after this many cycles.
    localparam int CYCLE_LIMIT = 200000;
    // The pipeline is two registers deep, so a few quiet cycles cover any tail.
    localparam int DRAIN_CYCLES = 8;
    localparam int IN_MIN = -1024;
    localparam int IN_MAX = 1023;
    localparam int ITEMS_PER_PHASE = 290;
    localparam int NUM_PHASES = 6;
    localparam int MAX_REPORTS = 10;

    // One input transaction as the stimulus process queues it.
    typedef struct {
        plr_pkg::t_op                    op;
        logic signed [plr_pkg::IN_W-1:0] sx;
        logic signed [plr_pkg::IN_W-1:0] sy;
        logic signed [plr_pkg::IN_W-1:0] ex;
        logic signed [plr_pkg::IN_W-1:0] ey;
    } t_line_cmd;

    // Every block input starts at a known value, so that no edge comes out of X.
    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [plr_pkg::CFG_IDX_W-1:0]    i_cfg_index = plr_pkg::REG_ORIGIN_X;
    logic [plr_pkg::ORG_W-1:0]        i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic                             i_operation = plr_pkg::OP_LOAD;
    logic signed [plr_pkg::IN_W-1:0]  i_start_x = '0;
    logic signed [plr_pkg::IN_W-1:0]  i_start_y = '0;
    logic signed [plr_pkg::IN_W-1:0]  i_end_x = '0;
    logic signed [plr_pkg::IN_W-1:0]  i_end_y = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic signed [plr_pkg::PIX_W-1:0] o_pixel_x;
    logic signed [plr_pkg::PIX_W-1:0] o_pixel_y;
    logic                             o_plot;
    logic                             o_last;

    // Stimulus and scoreboard bookkeeping.
    t_line_cmd        cmd_q[$];
    t_line_cmd        driver_cmd;
    plr_pkg::t_result expected_pixels[$];
    plr_pkg::t_result predicted_pixel;
    plr_pkg::t_result wanted_pixel;
    bit               in_taken = 1'b0;
    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               items_queued = 0;
    int               fail_count = 0;
    int               cycle_count = 0;

    // The bench's own copy of the origin registers and of the line state.
    logic [plr_pkg::ORG_W-1:0]        org_x = plr_pkg::ORIGIN_X_RST;
    logic [plr_pkg::ORG_W-1:0]        org_y = plr_pkg::ORIGIN_Y_RST;
    logic signed [plr_pkg::PIX_W-1:0] at_x = '0;
    logic signed [plr_pkg::PIX_W-1:0] at_y = '0;
    int                               err_acc = 0;
    int                               steps_done = 0;
    int                               major_len = 0;
    int                               minor_len = 0;
    bit                               x_neg = 1'b0;
    bit                               y_neg = 1'b0;
    bit                               x_major = 1'b0;
    bit                               drawing = 1'b0;
    logic [plr_pkg::PHASE_W-1:0]      dash_phase = '0;

    patterned_line_rasterizer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_plot      (o_plot),
        .o_last      (o_last)
    );

    // 2 ns clock. Rising edges fall on odd nanoseconds, falling edges on even ones.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Screen coordinates wrap to the coordinate width in two's complement.
    function automatic logic signed [plr_pkg::PIX_W-1:0] wrap_coord(input int v);
        logic [plr_pkg::COORD_WIDTH_DEF-1:0] low;
        low = v[plr_pkg::COORD_WIDTH_DEF-1:0];
        return plr_pkg::PIX_W'(signed'(low));
    endfunction

    function automatic logic signed [plr_pkg::IN_W-1:0] clamp_in(input int v);
        if (v < IN_MIN) begin
            v = IN_MIN;
        end else if (v > IN_MAX) begin
            v = IN_MAX;
        end
        return plr_pkg::IN_W'(v);
    endfunction

    // Works out the pixel that one accepted transaction produces and advances the
    // line state the way the stepper does.
    task automatic rasterize_item(input t_line_cmd c, output plr_pkg::t_result r);
        int  x1, y1, x2, y2, dx, dy, sgx, sgy;
        bit  minor_move;
        if (c.op == plr_pkg::OP_LOAD) begin
            // Centred endpoints become screen positions; y grows downward on screen.
            x1 = wrap_coord(int'(c.sx) + int'(org_x));
            y1 = wrap_coord(int'(org_y) - int'(c.sy));
            x2 = wrap_coord(int'(c.ex) + int'(org_x));
            y2 = wrap_coord(int'(org_y) - int'(c.ey));
            x_neg = x1 > x2;
            y_neg = y1 > y2;
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dy = (y2 > y1) ? y2 - y1 : y1 - y2;
            // A diagonal line (dx equal to dy) counts as y-major.
            x_major = dx > dy;
            major_len = x_major ? dx : dy;
            minor_len = x_major ? dy : dx;
            err_acc = 2 * minor_len - major_len;
            at_x = plr_pkg::PIX_W'(x1);
            at_y = plr_pkg::PIX_W'(y1);
            steps_done = 0;
            dash_phase = plr_pkg::PHASE_W'(1);
            drawing = major_len != 0;
            // The first pixel is always drawn; a single-pixel line ends right here.
            r.pixel_x = at_x;
            r.pixel_y = at_y;
            r.plot = 1'b1;
            r.last = !drawing;
        end else if (!drawing) begin
            // A step with nothing to draw leaves the state alone.
            r.pixel_x = '0;
            r.pixel_y = '0;
            r.plot = 1'b0;
            r.last = 1'b1;
        end else begin
            sgx = x_neg ? -1 : 1;
            sgy = y_neg ? -1 : 1;
            minor_move = err_acc >= 0;
            err_acc += 2 * minor_len;
            if (minor_move) begin
                err_acc -= 2 * major_len;
            end
            if (x_major) begin
                at_x = wrap_coord(int'(at_x) + sgx);
                if (minor_move) begin
                    at_y = wrap_coord(int'(at_y) + sgy);
                end
            end else begin
                at_y = wrap_coord(int'(at_y) + sgy);
                if (minor_move) begin
                    at_x = wrap_coord(int'(at_x) + sgx);
                end
            end
            steps_done++;
            dash_phase = plr_pkg::PHASE_W'((int'(dash_phase) + 1) %
                                           int'(plr_pkg::PATTERN_LEN));
            // X-major lines draw every third pixel, others skip one in fifteen.
            r.plot = x_major ? (dash_phase % 3 == 0) : (dash_phase != 0);
            r.last = steps_done >= major_len;
            if (r.last) begin
                drawing = 1'b0;
            end
            r.pixel_x = at_x;
            r.pixel_y = at_y;
        end
    endtask

    task automatic push_load(input int sx, input int sy, input int ex, input int ey);
        t_line_cmd c;
        c.op = plr_pkg::OP_LOAD;
        c.sx = plr_pkg::IN_W'(sx);
        c.sy = plr_pkg::IN_W'(sy);
        c.ex = plr_pkg::IN_W'(ex);
        c.ey = plr_pkg::IN_W'(ey);
        cmd_q.push_back(c);
        items_queued++;
    endtask

    // The endpoint fields of a step are ignored, so they carry random bits.
    task automatic push_step();
        t_line_cmd c;
        c.op = plr_pkg::OP_STEP;
        c.sx = plr_pkg::IN_W'($urandom);
        c.sy = plr_pkg::IN_W'($urandom);
        c.ex = plr_pkg::IN_W'($urandom);
        c.ey = plr_pkg::IN_W'($urandom);
        cmd_q.push_back(c);
        items_queued++;
    endtask

    // Queues a load for a line anywhere on the field whose end lies within reach of
    // its start, and returns the number of steps the line has.
    task automatic push_line(input int reach, output int span);
        int sx, sy, ex, ey, adx, ady;
        sx = int'($urandom_range(0, 2047)) - 1024;
        sy = int'($urandom_range(0, 2047)) - 1024;
        ex = clamp_in(sx + int'($urandom_range(0, 2 * reach)) - reach);
        ey = clamp_in(sy + int'($urandom_range(0, 2 * reach)) - reach);
        adx = (ex > sx) ? ex - sx : sx - ex;
        ady = (ey > sy) ? ey - sy : sy - ey;
        span = (adx > ady) ? adx : ady;
        push_load(sx, sy, ex, ey);
    endtask

    // One random sequence. Most are complete lines with random geometry, some are
    // cut short and replaced by the next load, the rest are lone noise transactions.
    task automatic queue_random_burst();
        int pick, span, reach, cut;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            reach = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                                 : $urandom_range(0, 24);
            push_line(reach, span);
            repeat (span) push_step();
            // Now and then, step past the end of the line as well.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) push_step();
            end
        end else if (pick < 90) begin
            push_line($urandom_range(0, 2047), span);
            cut = (span < 6) ? span : 6;
            repeat ($urandom_range(0, cut)) push_step();
        end else if ($urandom_range(0, 1) == 0) begin
            push_step();
        end else begin
            push_load(int'($urandom_range(0, 2047)) - 1024,
                      int'($urandom_range(0, 2047)) - 1024,
                      int'($urandom_range(0, 2047)) - 1024,
                      int'($urandom_range(0, 2047)) - 1024);
        end
    endtask

    // Register writes happen on falling edges while the block is idle, and the
    // bench's copy of the register follows at once.
    task automatic cfg_write(input logic [plr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plr_pkg::ORG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == plr_pkg::REG_ORIGIN_X) begin
            org_x = val;
        end else begin
            org_y = val;
        end
    endtask

    // Waits until every queued transaction has been sent and every prediction has
    // been matched, then lets the pipeline settle.
    task automatic wait_drained();
        while (cmd_q.size() != 0 || i_in_valid || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus. Reset once, then six phases. Each phase has its own origin setting.
    // Idle mix: sender 32 and receiver 50 percent in the first two phases, then the
    // other way round in the next two, and in the last two phases no idling at all.
    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            tx_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 50 : 0;
            rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 32 : 0;
            case (ph)
                1: begin
                    cfg_write(plr_pkg::REG_ORIGIN_X, '0);
                    cfg_write(plr_pkg::REG_ORIGIN_Y, '0);
                end
                2: begin
                    cfg_write(plr_pkg::REG_ORIGIN_X, '1);
                    cfg_write(plr_pkg::REG_ORIGIN_Y, '1);
                end
                3: begin
                    cfg_write(plr_pkg::REG_ORIGIN_X, '1);
                    cfg_write(plr_pkg::REG_ORIGIN_Y, '0);
                end
                4, 5: begin
                    cfg_write(plr_pkg::REG_ORIGIN_X,
                              plr_pkg::ORG_W'($urandom_range(0, 1023)));
                    cfg_write(plr_pkg::REG_ORIGIN_Y,
                              plr_pkg::ORG_W'($urandom_range(0, 1023)));
                end
                default: begin
                end
            endcase

            if (ph == 0) begin
                // Directed part at the reset origin. A step before any load has
                // no line to advance.
                push_step();
                // A single-pixel line at the field's extreme corner ends on load.
                push_load(IN_MAX, IN_MIN, IN_MAX, IN_MIN);
                push_step();
                // The full diagonal of the field, then a new load replaces it.
                push_load(IN_MIN, IN_MIN, IN_MAX, IN_MAX);
                push_step();
                push_step();
                // A shallow x-major line, run one step beyond its end.
                push_load(0, 0, 5, 2);
                repeat (6) push_step();
                // A steep line going left and down the screen.
                push_load(0, 0, -2, -4);
                repeat (4) push_step();
                // An exact diagonal toward the origin is treated as y-major.
                push_load(3, 3, 0, 0);
                repeat (3) push_step();
                // A vertical line upward.
                push_load(-1, 0, -1, 3);
                repeat (3) push_step();
            end

            target = items_queued + ITEMS_PER_PHASE;
            while (items_queued < target) begin
                queue_random_burst();
            end
        end

        wait_drained();
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("[patterned_line_rasterizer_top] OK");
        end else begin
            $display("[patterned_line_rasterizer_top] ERROR");
        end
        $finish;
    end

    // Driver. On each falling edge a new transaction is offered only once the
    // previous one has been accepted; an offered transaction holds until then.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (!i_in_valid || in_taken) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    driver_cmd = cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= driver_cmd.op;
                    i_start_x <= driver_cmd.sx;
                    i_start_y <= driver_cmd.sy;
                    i_end_x <= driver_cmd.ex;
                    i_end_y <= driver_cmd.ey;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor. On each rising edge, an accepted input transaction is predicted and
    // queued, and an accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                rasterize_item(driver_cmd, predicted_pixel);
                expected_pixels.push_back(predicted_pixel);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected result: x=%0d y=%0d plot=%0b last=%0b",
                                 o_pixel_x, o_pixel_y, o_plot, o_last);
                    end
                end else begin
                    wanted_pixel = expected_pixels.pop_front();
                    if (o_pixel_x !== wanted_pixel.pixel_x ||
                        o_pixel_y !== wanted_pixel.pixel_y ||
                        o_plot !== wanted_pixel.plot || o_last !== wanted_pixel.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch: expected x=%0d y=%0d plot=%0b last=%0b,",
                                     wanted_pixel.pixel_x, wanted_pixel.pixel_y,
                                     wanted_pixel.plot, wanted_pixel.last,
                                     " got x=%0d y=%0d plot=%0b last=%0b",
                                     o_pixel_x, o_pixel_y, o_plot, o_last);
                        end
                    end
                end
            end
        end
    end

    // Watchdog. A hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[patterned_line_rasterizer_top] ERROR");
            $finish;
        end
    end

endmodule

>>> patterned_line_rasterizer_top.f
hdl/plr_pkg.sv
hdl/plr_in_stage.sv
hdl/plr_stepper.sv
hdl/plr_out_reg.sv
hdl/patterned_line_rasterizer_top.sv
tb/sv/tb_patterned_line_rasterizer_top.sv
